// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PBU_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pixel_blend_unit check failed");

// next-cycle implication
`define PBU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pixel_blend_unit check failed");

`endif

// ----- rtl/pbu_pkg.sv -----
package pbu_pkg;

  localparam int unsigned CFG_W      = 13;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_W      = 24;
  localparam int unsigned DEN_W      = 16;
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned NUM_LANES  = 4;
  localparam int unsigned DIV_STEPS  = 8;
  localparam int unsigned LANE_DEPTH = 2 + DIV_STEPS;
  localparam int unsigned PIPE_DEPTH = LANE_DEPTH + 1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [1:0] {
    ACT_REPLACE = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_MULT    = 2'd2,
    ACT_OVER    = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [PIPE_DEPTH-1:0] en;
  } pipe_ctrl_t;

  // floor(x/255), exact for x up to 255*255
  function automatic logic [CHAN_W-1:0] div255(input logic [DEN_W-1:0] x);
    logic [DEN_W:0] t;
    t = (DEN_W+1)'(x) + (DEN_W+1)'(1) + (DEN_W+1)'(x[DEN_W-1:CHAN_W]);
    return t[DEN_W-1:CHAN_W];
  endfunction

endpackage

// ----- rtl/pbu_ctrl.sv -----
module pbu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pbu_pkg::pipe_ctrl_t ctrl_o
);

  localparam int unsigned N = pbu_pkg::PIPE_DEPTH;

  logic [N-1:0] vld_q, vld_d;
  logic [N-1:0] en;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[N-1] = !vld_q[N-1] || out_ready_i;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int i = 1; i < N; i++) begin
      if (en[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[N-1];
  assign ctrl_o.en   = en;

endmodule

// ----- rtl/pbu_lane.sv -----
module pbu_lane (
  input  logic                             clk_i,
  input  pbu_pkg::pipe_ctrl_t              ctrl_i,
  input  logic [pbu_pkg::CHAN_W-1:0]       s_i,
  input  logic [pbu_pkg::CHAN_W-1:0]       d_i,
  input  logic [pbu_pkg::CHAN_W-1:0]       sa_i,
  input  logic [pbu_pkg::CHAN_W-1:0]       da_i,
  input  pbu_pkg::action_e                 act_i,
  output logic [pbu_pkg::CHAN_W-1:0]       res_o,
  output logic [pbu_pkg::CHAN_W-1:0]       den_div_o,
  output logic                             over_o
);

  localparam int unsigned CW = pbu_pkg::CHAN_W;
  localparam int unsigned NW = pbu_pkg::NUM_W;
  localparam int unsigned DW = pbu_pkg::DEN_W;
  localparam int unsigned NS = pbu_pkg::DIV_STEPS;

  // stage 0: products
  logic [DW-1:0]    p1_q, p2_q, sd_q;
  logic [CW:0]      sum_q;
  logic [CW-1:0]    s0_q, d0_q, sa0_q;
  pbu_pkg::action_e act0_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      p1_q   <= DW'(sa_i) * DW'(s_i);
      p2_q   <= DW'(8'd255 - sa_i) * DW'(da_i);
      sd_q   <= DW'(s_i) * DW'(d_i);
      sum_q  <= (CW+1)'(s_i) + (CW+1)'(d_i);
      s0_q   <= s_i;
      d0_q   <= d_i;
      sa0_q  <= sa_i;
      act0_q <= act_i;
    end
  end

  // stage 1: numerator, denominator, simple actions
  logic [NW:0]   num_w;
  logic [DW:0]   den_w;
  logic [CW-1:0] fix_w;

  always_comb begin
    num_w = ((NW+1)'(p1_q) << 8) - (NW+1)'(p1_q) + ((NW+1)'(p2_q) * (NW+1)'(d0_q));
    den_w = ((DW+1)'(sa0_q) << 8) - (DW+1)'(sa0_q) + (DW+1)'(p2_q);
    case (act0_q)
      pbu_pkg::ACT_REPLACE: fix_w = s0_q;
      pbu_pkg::ACT_ADD:     fix_w = sum_q[CW] ? 8'd255 : sum_q[CW-1:0];
      pbu_pkg::ACT_MULT:    fix_w = pbu_pkg::div255(sd_q);
      default:              fix_w = '0;
    endcase
  end

  logic [NW-1:0] rem_q  [NS];
  logic [CW-1:0] quo_q  [NS+1];
  logic [DW-1:0] den_q  [NS+1];
  logic [CW-1:0] fix_q  [NS+1];
  logic [CW-1:0] dd_q   [NS+1];
  logic          over_q [NS+1];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      rem_q[0]  <= num_w[NW-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_w[DW-1:0];
      fix_q[0]  <= fix_w;
      dd_q[0]   <= pbu_pkg::div255(den_w[DW-1:0]);
      over_q[0] <= (act0_q == pbu_pkg::ACT_OVER);
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar j = 0; j < NS; j++) begin : g_div
    localparam int unsigned K = NS - 1 - j;
    logic [NW-1:0] dsh;
    logic          take;
    assign dsh  = NW'(den_q[j]) << K;
    assign take = (rem_q[j] >= dsh);

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en[2+j]) begin
        quo_q[j+1]  <= {quo_q[j][CW-2:0], take};
        den_q[j+1]  <= den_q[j];
        fix_q[j+1]  <= fix_q[j];
        dd_q[j+1]   <= dd_q[j];
        over_q[j+1] <= over_q[j];
      end
    end

    if (j < NS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (ctrl_i.en[2+j]) begin
          rem_q[j+1] <= take ? (rem_q[j] - dsh) : rem_q[j];
        end
      end
    end
  end

  // both alphas zero gives a zero colour
  assign res_o     = over_q[NS] ? ((den_q[NS] == '0) ? '0 : quo_q[NS]) : fix_q[NS];
  assign den_div_o = dd_q[NS];
  assign over_o    = over_q[NS];

endmodule

// ----- rtl/pbu_addr.sv -----
module pbu_addr #(
  parameter int unsigned DIM_W = 13
) (
  input  logic                        clk_i,
  input  pbu_pkg::pipe_ctrl_t         ctrl_i,
  input  logic signed [15:0]          pos_x_i,
  input  logic signed [15:0]          pos_y_i,
  input  logic [DIM_W-1:0]            width_i,
  input  logic [DIM_W-1:0]            height_i,
  output logic                        inside_o,
  output logic [pbu_pkg::ADDR_W-1:0]  addr_o
);

  localparam int unsigned AW    = pbu_pkg::ADDR_W;
  localparam int unsigned MUL_W = DIM_W + 16;
  localparam int unsigned SUM_W = (MUL_W + 1 > AW) ? MUL_W + 1 : AW;
  localparam int unsigned NDLY  = pbu_pkg::LANE_DEPTH - 1;

  logic             inside_w;
  logic [MUL_W-1:0] mul_q;
  logic [15:0]      x_q;
  logic             in0_q;
  logic [SUM_W-1:0] sum_w;

  logic [AW-1:0] addr_q   [NDLY];
  logic          inside_q [NDLY];

  assign inside_w = !pos_x_i[15] && !pos_y_i[15] &&
                    (32'(pos_x_i[14:0]) < 32'(width_i)) &&
                    (32'(pos_y_i[14:0]) < 32'(height_i));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      mul_q <= MUL_W'(width_i) * MUL_W'(pos_y_i);
      x_q   <= pos_x_i;
      in0_q <= inside_w;
    end
  end

  assign sum_w = SUM_W'(mul_q) + SUM_W'(x_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      addr_q[0]   <= sum_w[AW-1:0];
      inside_q[0] <= in0_q;
    end
  end

  for (genvar j = 1; j < NDLY; j++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (ctrl_i.en[1+j]) begin
        addr_q[j]   <= addr_q[j-1];
        inside_q[j] <= inside_q[j-1];
      end
    end
  end

  assign inside_o = inside_q[NDLY-1];
  assign addr_o   = addr_q[NDLY-1];

endmodule

// ----- rtl/pixel_blend_unit.sv -----
// Throughput: one beat per cycle while out_ready_i does not stall the output; eleven beats can be in flight.
// Depth is set by the over action: two product stages and an eight-step restoring divider
// in each of the four channel lanes, then the packing register.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets the frame to 640 x 480.
module pixel_blend_unit #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [7:0]  src_red_i,
  input  logic [7:0]  src_green_i,
  input  logic [7:0]  src_blue_i,
  input  logic [7:0]  src_alpha_i,
  input  logic [1:0]  action_i,
  input  logic [31:0] dest_pixel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        write_enable_o,
  output logic [23:0] pixel_address_o,
  output logic [31:0] new_pixel_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CW    = pbu_pkg::CHAN_W;
  localparam int unsigned NL    = pbu_pkg::NUM_LANES;
  localparam int unsigned OUT_S = pbu_pkg::PIPE_DEPTH - 1;

  // configuration
  logic [pbu_pkg::CFG_W-1:0] frame_width_q, frame_width_d;
  logic [pbu_pkg::CFG_W-1:0] frame_height_q, frame_height_d;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (wr_en) begin
      if (paddr[2] == pbu_pkg::REG_HEIGHT) begin
        frame_height_d = pwdata[pbu_pkg::CFG_W-1:0];
      end else begin
        frame_width_d = pwdata[pbu_pkg::CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= pbu_pkg::WIDTH_RESET;
      frame_height_q <= pbu_pkg::HEIGHT_RESET;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  assign prdata = (paddr[2] == pbu_pkg::REG_HEIGHT) ? 32'(frame_height_q)
                                                    : 32'(frame_width_q);

  logic [DIM_W-1:0] w_lim, h_lim;
  assign w_lim = (32'(frame_width_q) > MAX_DIM)  ? DIM_W'(MAX_DIM) : DIM_W'(frame_width_q);
  assign h_lim = (32'(frame_height_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(frame_height_q);

  // pipeline control
  pbu_pkg::pipe_ctrl_t ctrl;

  pbu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  // lanes: blue, green, red, alpha
  logic [CW-1:0] src_chan [NL];
  logic [CW-1:0] res_chan [NL];
  logic [CW-1:0] alpha_den_div;
  logic          alpha_over;

  assign src_chan[0] = src_blue_i;
  assign src_chan[1] = src_green_i;
  assign src_chan[2] = src_red_i;
  assign src_chan[3] = src_alpha_i;

  for (genvar i = 0; i < NL; i++) begin : g_lane
    if (i == NL - 1) begin : g_alpha
      pbu_lane u_lane (
        .clk_i     (clk_i),
        .ctrl_i    (ctrl),
        .s_i       (src_chan[i]),
        .d_i       (dest_pixel_i[CW*i +: CW]),
        .sa_i      (src_alpha_i),
        .da_i      (dest_pixel_i[31:24]),
        .act_i     (pbu_pkg::action_e'(action_i)),
        .res_o     (res_chan[i]),
        .den_div_o (alpha_den_div),
        .over_o    (alpha_over)
      );
    end else begin : g_colour
      pbu_lane u_lane (
        .clk_i     (clk_i),
        .ctrl_i    (ctrl),
        .s_i       (src_chan[i]),
        .d_i       (dest_pixel_i[CW*i +: CW]),
        .sa_i      (src_alpha_i),
        .da_i      (dest_pixel_i[31:24]),
        .act_i     (pbu_pkg::action_e'(action_i)),
        .res_o     (res_chan[i]),
        .den_div_o (),
        .over_o    ()
      );
    end
  end

  logic                       in_frame;
  logic [pbu_pkg::ADDR_W-1:0] addr;

  pbu_addr #(
    .DIM_W (DIM_W)
  ) u_addr (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .pos_x_i  (pos_x_i),
    .pos_y_i  (pos_y_i),
    .width_i  (w_lim),
    .height_i (h_lim),
    .inside_o (in_frame),
    .addr_o   (addr)
  );

  // merge and output register
  logic [CW-1:0] alpha_w;
  logic          we_q;
  logic [23:0]   addr_q;
  logic [31:0]   pix_q;

  assign alpha_w = alpha_over ? alpha_den_div : res_chan[3];

  always_ff @(posedge clk_i) begin
    if (ctrl.en[OUT_S]) begin
      we_q   <= in_frame;
      addr_q <= in_frame ? addr : '0;
      pix_q  <= in_frame ? {alpha_w, res_chan[2], res_chan[1], res_chan[0]} : '0;
    end
  end

  assign write_enable_o  = we_q;
  assign pixel_address_o = addr_q;
  assign new_pixel_o     = pix_q;

endmodule

// ----- rtl/pbu_checker.sv -----
`include "assert_macros.svh"

module pbu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        write_enable_o,
  input logic [23:0] pixel_address_o,
  input logic [31:0] new_pixel_o
);

  // a waiting result beat holds
  `PBU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(write_enable_o) && $stable(pixel_address_o) && $stable(new_pixel_o))

  // points off the frame carry zero payload
  `PBU_ASSERT(a_off_zero, out_valid_o && !write_enable_o, (pixel_address_o == 24'd0) && (new_pixel_o == 32'd0))

  // an empty output stage means the whole pipe can take a beat
  `PBU_ASSERT(a_ready_empty, !out_valid_o, in_ready_o)

  // nothing comes out straight after reset
  `PBU_ASSERT(a_rst_empty, $rose(rst_ni), !out_valid_o)

endmodule

bind pixel_blend_unit pbu_checker u_pbu_checker (.*);

// ----- tb/sv/tb_pixel_blend_unit.sv -----
module tb_pixel_blend_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIM        = 4096;
  localparam int unsigned PIPE_LATENCY   = 11;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES    = 120;
  localparam int unsigned MAX_REPORTS    = 100;

  typedef struct {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         src_red;
    logic [7:0]         src_green;
    logic [7:0]         src_blue;
    logic [7:0]         src_alpha;
    pbu_pkg::action_e   action;
    logic [31:0]        dest_pixel;
  } pixel_item_t;

  typedef struct {
    logic        write_enable;
    logic [23:0] pixel_address;
    logic [31:0] new_pixel;
  } blend_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] pos_x_i;
  logic [15:0] pos_y_i;
  logic [7:0]  src_red_i;
  logic [7:0]  src_green_i;
  logic [7:0]  src_blue_i;
  logic [7:0]  src_alpha_i;
  logic [1:0]  action_i;
  logic [31:0] dest_pixel_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        write_enable_o;
  logic [23:0] pixel_address_o;
  logic [31:0] new_pixel_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [12:0]   frame_w;
  logic [12:0]   frame_h;
  blend_result_t pending_pixels[$];
  int unsigned   mismatch_count;
  int unsigned   result_beats;
  int unsigned   stuck_cycles;
  bit            hold_req;
  bit            holding;

  pixel_blend_unit #(
    .MAX_DIM(MAX_DIM)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .src_red_i      (src_red_i),
    .src_green_i    (src_green_i),
    .src_blue_i     (src_blue_i),
    .src_alpha_i    (src_alpha_i),
    .action_i       (action_i),
    .dest_pixel_i   (dest_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_enable_o (write_enable_o),
    .pixel_address_o(pixel_address_o),
    .new_pixel_o    (new_pixel_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(logic [12:0] v);
    return (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic logic [7:0] mix_channel(pbu_pkg::action_e act, int unsigned s,
                                             int unsigned d, int unsigned sa,
                                             int unsigned da);
    int unsigned sum;
    int unsigned num;
    int unsigned den;
    sum = s + d;
    den = 255 * sa + (255 - sa) * da;
    num = 255 * sa * s + (255 - sa) * da * d;
    case (act)
      pbu_pkg::ACT_REPLACE: return 8'(s);
      pbu_pkg::ACT_ADD:     return (sum > 255) ? 8'd255 : 8'(sum);
      pbu_pkg::ACT_MULT:    return 8'((s * d) / 255);
      default:              return (den == 0) ? 8'd0 : 8'(num / den);
    endcase
  endfunction

  function automatic blend_result_t predict_blend(pixel_item_t p);
    blend_result_t r;
    int            xs;
    int            ys;
    int unsigned   w;
    int unsigned   h;
    int unsigned   sa;
    int unsigned   da;
    logic [7:0]    a;
    w  = clamp_dim(frame_w);
    h  = clamp_dim(frame_h);
    xs = p.pos_x;
    ys = p.pos_y;
    sa = p.src_alpha;
    da = p.dest_pixel[31:24];
    r.write_enable  = 1'b0;
    r.pixel_address = '0;
    r.new_pixel     = '0;
    if (xs < 0 || ys < 0 || xs >= int'(w) || ys >= int'(h)) return r;
    if (p.action == pbu_pkg::ACT_OVER) a = 8'((255 * sa + (255 - sa) * da) / 255);
    else a = mix_channel(p.action, sa, da, sa, da);
    r.write_enable  = 1'b1;
    r.pixel_address = 24'(w * int'(ys) + int'(xs));
    r.new_pixel     = {a,
                       mix_channel(p.action, p.src_red, p.dest_pixel[23:16], sa, da),
                       mix_channel(p.action, p.src_green, p.dest_pixel[15:8], sa, da),
                       mix_channel(p.action, p.src_blue, p.dest_pixel[7:0], sa, da)};
    return r;
  endfunction

  function automatic pixel_item_t make_item(int x, int y, logic [7:0] r, logic [7:0] g,
                                            logic [7:0] b, logic [7:0] a,
                                            pbu_pkg::action_e act, logic [31:0] dest);
    pixel_item_t p;
    p.pos_x      = 16'(x);
    p.pos_y      = 16'(y);
    p.src_red    = r;
    p.src_green  = g;
    p.src_blue   = b;
    p.src_alpha  = a;
    p.action     = act;
    p.dest_pixel = dest;
    return p;
  endfunction

  function automatic logic [7:0] pick_level();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_coord(int unsigned lim);
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (lim > 0 && mode < 7) return 16'($urandom_range(0, lim - 1));
    if (mode < 8) return 16'(int'(lim) - 2 + int'($urandom_range(0, 3)));
    if (mode < 9) return 16'(-int'($urandom_range(1, 3)));
    return 16'($urandom);
  endfunction

  function automatic pixel_item_t random_pixel();
    pixel_item_t p;
    p.pos_x      = pick_coord(clamp_dim(frame_w));
    p.pos_y      = pick_coord(clamp_dim(frame_h));
    p.src_red    = pick_level();
    p.src_green  = pick_level();
    p.src_blue   = pick_level();
    p.src_alpha  = pick_level();
    p.action     = pbu_pkg::action_e'($urandom_range(0, 3));
    p.dest_pixel = $urandom;
    if ($urandom_range(0, 9) < 3) p.dest_pixel[31:24] = pick_level();
    return p;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: result beat %0d %s: got %h, want %h", $realtime, result_beats, what,
               got, want);
  endtask

  task automatic send_pixel(pixel_item_t p, int unsigned gap);
    in_valid_i   <= 1'b1;
    pos_x_i      <= p.pos_x;
    pos_y_i      <= p.pos_y;
    src_red_i    <= p.src_red;
    src_green_i  <= p.src_green;
    src_blue_i   <= p.src_blue;
    src_alpha_i  <= p.src_alpha;
    action_i     <= p.action;
    dest_pixel_i <= p.dest_pixel;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pixels.push_back(predict_blend(p));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
  endtask

  task automatic write_register(pbu_pkg::reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == pbu_pkg::REG_WIDTH) frame_w = value[12:0];
    else frame_h = value[12:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame(logic [31:0] w, logic [31:0] h);
    wait_drained();
    write_register(pbu_pkg::REG_WIDTH, w);
    write_register(pbu_pkg::REG_HEIGHT, h);
  endtask

  task automatic test_reset_frame();
    send_pixel(make_item(0, 0, 8'h12, 8'h34, 8'h56, 8'h78, pbu_pkg::ACT_REPLACE,
                         32'h0), 0);
    send_pixel(make_item(639, 479, 8'hff, 8'hff, 8'hff, 8'hff, pbu_pkg::ACT_REPLACE,
                         32'h0), 0);
    send_pixel(make_item(640, 0, 8'h11, 8'h22, 8'h33, 8'h44, pbu_pkg::ACT_ADD,
                         32'h01020304), 1);
    send_pixel(make_item(0, 480, 8'h11, 8'h22, 8'h33, 8'h44, pbu_pkg::ACT_MULT,
                         32'hffffffff), 0);
    send_pixel(make_item(-1, 5, 8'h80, 8'h80, 8'h80, 8'h80, pbu_pkg::ACT_OVER,
                         32'h80808080), 0);
    send_pixel(make_item(5, -1, 8'h80, 8'h80, 8'h80, 8'h80, pbu_pkg::ACT_OVER,
                         32'h80808080), 2);
    send_pixel(make_item(-32768, -32768, 8'hff, 8'h0, 8'hff, 8'h0, pbu_pkg::ACT_ADD,
                         32'hffffffff), 0);
    send_pixel(make_item(32767, 32767, 8'h0, 8'hff, 8'h0, 8'hff, pbu_pkg::ACT_ADD,
                         32'hffffffff), 0);
    wait_drained();
  endtask

  task automatic test_actions();
    send_pixel(make_item(10, 10, 8'hff, 8'hff, 8'hff, 8'hff, pbu_pkg::ACT_REPLACE,
                         32'h0), 0);
    send_pixel(make_item(11, 10, 8'd200, 8'd100, 8'd255, 8'd200, pbu_pkg::ACT_ADD,
                         32'h80808080), 0);
    send_pixel(make_item(12, 10, 8'd1, 8'd0, 8'd1, 8'd0, pbu_pkg::ACT_ADD, 32'h0), 0);
    send_pixel(make_item(13, 10, 8'hff, 8'hff, 8'hff, 8'hff, pbu_pkg::ACT_MULT,
                         32'hffffffff), 0);
    send_pixel(make_item(14, 10, 8'd128, 8'd0, 8'd255, 8'd128, pbu_pkg::ACT_MULT,
                         32'h40404040), 0);
    // both alphas transparent
    send_pixel(make_item(15, 10, 8'hab, 8'hcd, 8'hef, 8'h0, pbu_pkg::ACT_OVER,
                         32'h00123456), 0);
    send_pixel(make_item(16, 10, 8'hab, 8'hcd, 8'hef, 8'hff, pbu_pkg::ACT_OVER,
                         32'hff123456), 0);
    send_pixel(make_item(17, 10, 8'hab, 8'hcd, 8'hef, 8'h0, pbu_pkg::ACT_OVER,
                         32'hff123456), 0);
    send_pixel(make_item(18, 10, 8'hc8, 8'h10, 8'h7f, 8'd128, pbu_pkg::ACT_OVER,
                         32'h40f00380), 0);
    wait_drained();
  endtask

  task automatic test_frame_limits();
    set_frame(1, 1);
    send_pixel(make_item(0, 0, 8'h5a, 8'ha5, 8'h3c, 8'hc3, pbu_pkg::ACT_ADD, $urandom), 0);
    send_pixel(make_item(1, 0, 8'h5a, 8'ha5, 8'h3c, 8'hc3, pbu_pkg::ACT_ADD, $urandom), 0);
    send_pixel(make_item(0, 1, 8'h5a, 8'ha5, 8'h3c, 8'hc3, pbu_pkg::ACT_ADD, $urandom), 0);
    set_frame(4096, 4096);
    send_pixel(make_item(4095, 4095, 8'h1, 8'h2, 8'h3, 8'h4, pbu_pkg::ACT_MULT,
                         $urandom), 0);
    send_pixel(make_item(4096, 0, 8'h1, 8'h2, 8'h3, 8'h4, pbu_pkg::ACT_MULT,
                         $urandom), 0);
    // values above the maximum dimension saturate
    set_frame(8191, 8191);
    send_pixel(make_item(4095, 4095, 8'h9, 8'h8, 8'h7, 8'h6, pbu_pkg::ACT_OVER,
                         $urandom), 0);
    send_pixel(make_item(0, 4096, 8'h9, 8'h8, 8'h7, 8'h6, pbu_pkg::ACT_OVER,
                         $urandom), 0);
    set_frame(0, 0);
    send_pixel(make_item(0, 0, 8'hff, 8'hff, 8'hff, 8'hff, pbu_pkg::ACT_REPLACE,
                         $urandom), 0);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    set_frame(4096, 4096);
    hold_req = 1'b1;
    while (!holding) @(posedge clk_i);
    repeat (40) send_pixel(random_pixel(), 0);
    wait_drained();
  endtask

  task automatic test_random_pixels();
    int unsigned count;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_frame(640, 480);
        1: set_frame(1, 1);
        2: set_frame(4096, 1);
        3: set_frame(8191, 8191);
        4: set_frame(0, 4096);
        5: set_frame($urandom_range(1, 4096), $urandom_range(1, 4096));
        6: set_frame({19'($urandom), 13'($urandom_range(1, 8191))},
                     {19'($urandom), 13'($urandom_range(1, 8191))});
        default: set_frame(4096, 4096);
      endcase
      count = (ph == 4) ? 50 : 240;
      for (int i = 0; i < count; i++) begin
        send_pixel(random_pixel(), ((i / 60) % 3 == 0) ? 0 : pick_gap());
        if ($urandom_range(0, 149) == 0) wait_drained();
      end
    end
    wait_drained();
  endtask

  // output side: random stalls, plus one long hold on request
  initial begin
    int unsigned run_len;
    int unsigned stall_len;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holding = 1'b0;
      end else begin
        run_len   = $urandom_range(1, 40);
        stall_len = pick_gap();
        out_ready_i <= 1'b1;
        repeat (run_len) @(posedge clk_i);
        if (stall_len > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall_len) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    blend_result_t want_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("beat with nothing pending", new_pixel_o, 32'h0);
      end else begin
        want_res = pending_pixels.pop_front();
        if (write_enable_o !== want_res.write_enable)
          report_mismatch("write_enable", 32'(write_enable_o), 32'(want_res.write_enable));
        if (pixel_address_o !== want_res.pixel_address)
          report_mismatch("pixel_address", 32'(pixel_address_o), 32'(want_res.pixel_address));
        if (new_pixel_o !== want_res.new_pixel)
          report_mismatch("new_pixel", new_pixel_o, want_res.new_pixel);
      end
      result_beats++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    pos_x_i      <= '0;
    pos_y_i      <= '0;
    src_red_i    <= '0;
    src_green_i  <= '0;
    src_blue_i   <= '0;
    src_alpha_i  <= '0;
    action_i     <= pbu_pkg::ACT_REPLACE;
    dest_pixel_i <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    frame_w      = pbu_pkg::WIDTH_RESET;
    frame_h      = pbu_pkg::HEIGHT_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_frame();
    test_actions();
    test_frame_limits();
    test_output_backpressure();
    test_random_pixels();
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
